### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the AES-128 CFB8 stream cipher.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hdl/aes_cfb_pkg.sv
// Package for the AES-128 CFB8 stream cipher: register indexes, S-box and round functions.
// No dependencies.
package aes_cfb_pkg;

    localparam int NumRounds = 10;

    typedef enum logic [2:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3,
        REG_MODE     = 3'd4
    } reg_index_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        t  = sub_rot_word(k[31:0]) ^ {rc, 24'h0};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic mix);
        logic [127:0] t;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (c * 4 + i) -: 8] =
                    SBOX[s[127 - 8 * (((c + i) % 4) * 4 + i) -: 8]];
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[127 - 32 * c -: 8];
                a1 = t[119 - 32 * c -: 8];
                a2 = t[111 - 32 * c -: 8];
                a3 = t[103 - 32 * c -: 8];
                t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return t ^ rk;
    endfunction

endpackage

### hdl/aes_cfb_stream_if.sv
// Valid/ready stream interfaces for the input and result bytes of the CFB8 cipher.
// No dependencies.
interface aes_cfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_flag;

    modport source (output valid, output data_byte, output final_flag, input ready);
    modport sink (input valid, input data_byte, input final_flag, output ready);
endinterface

interface aes_cfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       final_out;

    modport source (output valid, output result_byte, output final_out, input ready);
    modport sink (input valid, input result_byte, input final_out, output ready);
endinterface

### hdl/aes128_cfb8_stream_cipher.sv
// Top level of the byte-wide AES-128 CFB8 stream cipher.
// Depends on aes_cfb_pkg, aes_cfb_stream_if.sv and assert_macros.svh.
//
//   channel     direction  transfer contents
//   in_stream   sink       data_byte, final_flag
//   out_stream  source     result_byte, final_out
//   cfg_*       write      cfg_index, cfg_data
//
// The full ten-round cipher of the shift register runs
// between the shift register and the result register, and sets the clock period.
// Results appear in the cycle after input; one byte is taken per cycle unless stalled.
// Reset clears key, IV and shift register and selects encryption.
// A stalled result register blocks new input only while it is full and not taken.
`include "assert_macros.svh"

module aes128_cfb8_stream_cipher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    aes_cfb_in_if.sink             in_stream,
    aes_cfb_out_if.source          out_stream
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [63:0]  iv_high_reg;
    logic [63:0]  iv_low_reg;
    logic         mode_reg;
    logic [127:0] sr_reg;
    logic [127:0] sr_next;
    logic         out_valid_reg;
    logic [7:0]   result_reg;
    logic         final_reg;

    logic [127:0] round_key [aes_cfb_pkg::NumRounds + 1];
    logic [127:0] state [aes_cfb_pkg::NumRounds + 1];
    logic [7:0]   res_byte;
    logic         accept;

    assign round_key[0] = {key_high_reg, key_low_reg};
    assign state[0]     = sr_reg ^ round_key[0];

    for (genvar r = 1; r <= aes_cfb_pkg::NumRounds; r++) begin : g_round
        assign round_key[r] = aes_cfb_pkg::next_round_key(round_key[r - 1],
                                                         aes_cfb_pkg::RCON[r - 1]);
        assign state[r] = aes_cfb_pkg::aes_round(state[r - 1], round_key[r],
                                                 r != aes_cfb_pkg::NumRounds);
    end

    assign res_byte        = in_stream.data_byte ^ state[aes_cfb_pkg::NumRounds][127:120];
    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign accept          = in_stream.valid && in_stream.ready;

    always_comb
    begin
        sr_next = sr_reg;
        if (cfg_we && (cfg_index == aes_cfb_pkg::REG_IV_HIGH)) begin
            sr_next = {cfg_data, iv_low_reg};
        end else if (cfg_we && (cfg_index == aes_cfb_pkg::REG_IV_LOW)) begin
            sr_next = {iv_high_reg, cfg_data};
        end else if (accept) begin
            sr_next = {sr_reg[119:0], mode_reg ? res_byte : in_stream.data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            mode_reg      <= 1'b1;
            sr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sr_reg <= sr_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    aes_cfb_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                    aes_cfb_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    aes_cfb_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                    aes_cfb_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                    aes_cfb_pkg::REG_MODE:     mode_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (out_stream.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= res_byte;
            final_reg  <= in_stream.final_flag;
        end
    end

    assign out_stream.valid       = out_valid_reg;
    assign out_stream.result_byte = result_reg;
    assign out_stream.final_out   = final_reg;

    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `ASSERT_NEXT(a_iv_reload, clk, rst_n,
        cfg_we && (cfg_index == aes_cfb_pkg::REG_IV_LOW), sr_reg == {iv_high_reg, iv_low_reg})
    `ASSERT_NEXT(a_mode_write, clk, rst_n,
        cfg_we && (cfg_index == aes_cfb_pkg::REG_MODE), mode_reg == $past(cfg_data[0]))

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the byte-wide AES-128 CFB8 stream cipher.
// Depends on aes_cfb_pkg, aes_cfb_stream_if.sv and the cipher RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       final_out;
    } cfb_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    aes_cfb_in_if  in_stream ();
    aes_cfb_out_if out_stream ();

    aes128_cfb8_stream_cipher u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_stream  (in_stream.sink),
        .out_stream (out_stream.source)
    );

    localparam int WatchdogLimit = 20000;

    logic [63:0]  key_hi_q;
    logic [63:0]  key_lo_q;
    logic [63:0]  iv_hi_q;
    logic [63:0]  iv_lo_q;
    logic         encrypt_q;
    logic [127:0] feedback_reg;
    logic [127:0] key_sched [aes_cfb_pkg::NumRounds + 1];

    cfb_result_t  pending_results [$];
    int           error_count;
    int           byte_count;
    int           result_count;
    int           idle_cycles;
    bit           timed_out;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic expand_key_sched();
        logic [127:0] k;
        logic [31:0]  t;
        logic [31:0]  w0;
        logic [31:0]  w1;
        logic [31:0]  w2;
        logic [31:0]  w3;
        logic [7:0]   rc;
        k  = {key_hi_q, key_lo_q};
        rc = 8'h01;
        key_sched[0] = k;
        for (int r = 1; r <= aes_cfb_pkg::NumRounds; r++)
        begin
            t  = {aes_cfb_pkg::SBOX[k[23:16]] ^ rc, aes_cfb_pkg::SBOX[k[15:8]],
                  aes_cfb_pkg::SBOX[k[7:0]], aes_cfb_pkg::SBOX[k[31:24]]};
            w0 = k[127:96] ^ t;
            w1 = k[95:64] ^ w0;
            w2 = k[63:32] ^ w1;
            w3 = k[31:0] ^ w2;
            k  = {w0, w1, w2, w3};
            key_sched[r] = k;
            rc = gf_double(rc);
        end
    endtask

    function automatic logic [7:0] cipher_first_byte(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8] ^ key_sched[0][127 - 8 * i -: 8];
        for (int r = 1; r <= aes_cfb_pkg::NumRounds; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c * 4 + i] = aes_cfb_pkg::SBOX[s[((c + i) % 4) * 4 + i]];
            if (r != aes_cfb_pkg::NumRounds)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[c * 4];
                    a1 = t[c * 4 + 1];
                    a2 = t[c * 4 + 2];
                    a3 = t[c * 4 + 3];
                    t[c * 4]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    t[c * 4 + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    t[c * 4 + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    t[c * 4 + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ key_sched[r][127 - 8 * i -: 8];
        end
        return s[0];
    endfunction

    task automatic predict_byte(input logic [7:0] din, input logic fin);
        cfb_result_t res;
        res.result_byte = din ^ cipher_first_byte(feedback_reg);
        res.final_out   = fin;
        feedback_reg    = {feedback_reg[119:0], encrypt_q ? res.result_byte : din};
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        error_count++;
        $display("ERROR @%0t: %s got %0h, expected %0h", $realtime, what, got, exp_val);
    endtask

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input aes_cfb_pkg::reg_index_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            aes_cfb_pkg::REG_KEY_HIGH:
            begin
                key_hi_q = value;
                expand_key_sched();
            end
            aes_cfb_pkg::REG_KEY_LOW:
            begin
                key_lo_q = value;
                expand_key_sched();
            end
            aes_cfb_pkg::REG_IV_HIGH:
            begin
                iv_hi_q = value;
                feedback_reg = {iv_hi_q, iv_lo_q};
            end
            aes_cfb_pkg::REG_IV_LOW:
            begin
                iv_lo_q = value;
                feedback_reg = {iv_hi_q, iv_lo_q};
            end
            aes_cfb_pkg::REG_MODE: encrypt_q = value[0];
            default: ;
        endcase
    endtask

    task automatic write_unknown_index(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] din, input logic fin);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            in_stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_stream.valid      <= 1'b1;
        in_stream.data_byte  <= din;
        in_stream.final_flag <= fin;
        @(posedge clk);
        while (!in_stream.ready)
            @(posedge clk);
        predict_byte(din, fin);
        byte_count++;
    endtask

    task automatic end_burst();
        in_stream.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        for (int i = 0; i < 4; i++)
            send_byte(8'h00, i == 3);
        end_burst();
        drain();
    endtask

    task automatic test_directed_extremes();
        write_reg(aes_cfb_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(aes_cfb_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(aes_cfb_pkg::REG_IV_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(aes_cfb_pkg::REG_IV_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        end_burst();
        drain();
        // The mode register keeps only its low bit.
        write_reg(aes_cfb_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_unknown_index(3'd5, 64'h1234_5678_9ABC_DEF0);
        write_unknown_index(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_byte(i[0] ? 8'hFF : 8'h00, i == 5);
        end_burst();
        drain();
        write_reg(aes_cfb_pkg::REG_MODE, 64'h1);
        write_reg(aes_cfb_pkg::REG_IV_LOW, 64'h0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        end_burst();
        drain();
    endtask

    task automatic test_random_streams(input int total);
        int sent;
        int burst;
        sent = 0;
        while (sent < total)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(aes_cfb_pkg::REG_KEY_HIGH, {$urandom, $urandom});
                1: write_reg(aes_cfb_pkg::REG_KEY_LOW, {$urandom, $urandom});
                default: ;
            endcase
            if ($urandom_range(0, 1))
                write_reg(aes_cfb_pkg::REG_IV_HIGH, {$urandom, $urandom});
            if ($urandom_range(0, 1))
                write_reg(aes_cfb_pkg::REG_IV_LOW, {$urandom, $urandom});
            write_reg(aes_cfb_pkg::REG_MODE, {$urandom, $urandom});
            burst = (sent % 5 == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == burst - 1) || ($urandom_range(0, 15) == 0));
            sent += burst;
            end_burst();
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        cfb_result_t exp_res;
        if (rst_n && out_stream.valid && out_stream.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("ERROR @%0t: result %0h with nothing expected", $realtime,
                         out_stream.result_byte);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_stream.result_byte !== exp_res.result_byte)
                    report_mismatch("result_byte", out_stream.result_byte,
                                    exp_res.result_byte);
                if (out_stream.final_out !== exp_res.final_out)
                    report_mismatch("final_out", {7'b0, out_stream.final_out},
                                    {7'b0, exp_res.final_out});
            end
        end
    end

    always @(posedge clk)
    begin
        int stall;
        if (stall > 0)
        begin
            stall--;
            out_stream.ready <= 1'b0;
        end
        else
        begin
            stall = ($urandom_range(0, 2) == 0) ? random_gap() : 0;
            out_stream.ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_stream.valid && in_stream.ready) || (out_stream.valid && out_stream.ready)
            || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("ERROR: no transfer for %0d cycles", WatchdogLimit);
            $display("** aes128_cfb8_stream_cipher: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_stream.valid      = 1'b0;
        in_stream.data_byte  = '0;
        in_stream.final_flag = 1'b0;
        out_stream.ready     = 1'b0;
        error_count          = 0;
        byte_count           = 0;
        result_count         = 0;
        idle_cycles          = 0;
        timed_out            = 1'b0;
        key_hi_q             = '0;
        key_lo_q             = '0;
        iv_hi_q              = '0;
        iv_lo_q              = '0;
        encrypt_q            = 1'b1;
        feedback_reg         = '0;
        expand_key_sched();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_extremes();
        test_random_streams(1700);

        $display("Covered %0d input bytes and %0d results over key, IV and mode changes,",
                 byte_count, result_count);
        $display("with both cipher directions and random stalls on both streams.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("** aes128_cfb8_stream_cipher: PASSED **");
        else
            $display("** aes128_cfb8_stream_cipher: FAILED **");
        $finish;
    end
endmodule
